FILE: design/pba_pkg.sv
// shared types, widths and saturation helpers for the peak background area block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pba_pkg;

  localparam int SampleW = 32;
  localparam int AreaW   = 48;
  localparam int HeightW = 33;
  localparam int WideW   = 50;

  // one input item as it sits in the input register
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      first;
    logic                      is_apex;
    logic                      last;
  } item_t;

  // accumulated values handed to the result stage on a last sample
  typedef struct packed {
    logic signed [AreaW-1:0]   raw_sum;
    logic signed [AreaW-1:0]   bg_sum;
    logic signed [SampleW-1:0] apex_raw;
    logic signed [SampleW-1:0] apex_bg;
    logic                      apex_flag;
  } result_t;

  // clamp a wide signed value to the signed 48-bit range
  function automatic logic signed [AreaW-1:0] sat48(input logic signed [WideW-1:0] v);
    logic signed [AreaW-1:0] r;
    if (v[WideW-1:AreaW-1] == {(WideW-AreaW+1){1'b0}} ||
        v[WideW-1:AreaW-1] == {(WideW-AreaW+1){1'b1}}) begin
      r = v[AreaW-1:0];
    end else if (v[WideW-1]) begin
      r = {1'b1, {(AreaW-1){1'b0}}};
    end else begin
      r = {1'b0, {(AreaW-1){1'b1}}};
    end
    return r;
  endfunction

  // clamp a 33-bit signed value to the signed 32-bit range
  function automatic logic signed [SampleW-1:0] sat32(input logic signed [SampleW:0] v);
    logic signed [SampleW-1:0] r;
    if (v[SampleW] == v[SampleW-1]) begin
      r = v[SampleW-1:0];
    end else if (v[SampleW]) begin
      r = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SampleW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: design/pba_accum.sv
// region state: background line, previous points, doubled area sums and apex hold
// depends on pba_pkg (item_t, result_t, sat32, sat48)
`timescale 1ns / 1ps

module pba_accum (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  pba_pkg::item_t                   item,
  input  logic signed [pba_pkg::SampleW-1:0] bg_slope,
  output pba_pkg::result_t                 res_next
);
  import pba_pkg::*;

  logic signed [SampleW-1:0] bg_line, bg_line_next;
  logic signed [SampleW-1:0] prev_raw, prev_bg;
  logic signed [AreaW-1:0]   raw_sum, raw_sum_next;
  logic signed [AreaW-1:0]   bg_sum, bg_sum_next;
  logic signed [SampleW-1:0] apex_raw_hold, apex_raw_next;
  logic signed [SampleW-1:0] apex_bg_hold, apex_bg_next;
  logic                      apex_flag, apex_flag_next;

  logic signed [SampleW-1:0] line_eff;
  logic signed [SampleW-1:0] bgp;
  logic signed [SampleW:0]   line_sum;

  always_comb begin
    // the first sample of a region restarts the line at the sample itself
    line_eff = item.first ? item.sample : bg_line;
    bgp      = (item.sample < line_eff) ? item.sample : line_eff;
    line_sum = SampleW'(0) + (SampleW+1)'(line_eff) + (SampleW+1)'(bg_slope);
    bg_line_next = sat32(line_sum);

    if (item.first) begin
      raw_sum_next = '0;
      bg_sum_next  = '0;
    end else begin
      raw_sum_next = sat48(WideW'(raw_sum) + WideW'(prev_raw) + WideW'(item.sample));
      bg_sum_next  = sat48(WideW'(bg_sum) + WideW'(prev_bg) + WideW'(bgp));
    end

    if (item.is_apex) begin
      apex_raw_next  = item.sample;
      apex_bg_next   = bgp;
      apex_flag_next = 1'b1;
    end else if (item.first) begin
      apex_raw_next  = '0;
      apex_bg_next   = '0;
      apex_flag_next = 1'b0;
    end else begin
      apex_raw_next  = apex_raw_hold;
      apex_bg_next   = apex_bg_hold;
      apex_flag_next = apex_flag;
    end

    res_next.raw_sum   = raw_sum_next;
    res_next.bg_sum    = bg_sum_next;
    res_next.apex_raw  = apex_raw_next;
    res_next.apex_bg   = apex_bg_next;
    res_next.apex_flag = apex_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_line       <= '0;
      prev_raw      <= '0;
      prev_bg       <= '0;
      raw_sum       <= '0;
      bg_sum        <= '0;
      apex_raw_hold <= '0;
      apex_bg_hold  <= '0;
      apex_flag     <= 1'b0;
    end else if (step) begin
      bg_line       <= bg_line_next;
      prev_raw      <= item.sample;
      prev_bg       <= bgp;
      raw_sum       <= raw_sum_next;
      bg_sum        <= bg_sum_next;
      apex_raw_hold <= apex_raw_next;
      apex_bg_hold  <= apex_bg_next;
      apex_flag     <= apex_flag_next;
    end
  end

endmodule

FILE: design/pba_result.sv
// output register: peak area and apex height formed from the held region values
// depends on pba_pkg (result_t, sat48)
`timescale 1ns / 1ps

module pba_result (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               mid_valid,
  input  pba_pkg::result_t                   mid,
  output logic                               out_ready,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pba_pkg::AreaW-1:0]   raw_area_x2,
  output logic signed [pba_pkg::AreaW-1:0]   bg_area_x2,
  output logic signed [pba_pkg::AreaW-1:0]   peak_area_x2,
  output logic signed [pba_pkg::SampleW-1:0] apex_raw,
  output logic signed [pba_pkg::HeightW-1:0] apex_height,
  output logic                               apex_seen
);
  import pba_pkg::*;

  logic signed [AreaW-1:0]   peak_next;
  logic signed [HeightW-1:0] height_next;
  logic signed [SampleW-1:0] apex_next;

  assign out_ready = !out_valid || !out_stall;

  always_comb begin
    peak_next = sat48(WideW'(mid.raw_sum) - WideW'(mid.bg_sum));
    if (mid.apex_flag) begin
      apex_next   = mid.apex_raw;
      height_next = HeightW'(mid.apex_raw) - HeightW'(mid.apex_bg);
    end else begin
      apex_next   = '0;
      height_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && mid_valid) begin
      raw_area_x2  <= mid.raw_sum;
      bg_area_x2   <= mid.bg_sum;
      peak_area_x2 <= peak_next;
      apex_raw     <= apex_next;
      apex_height  <= height_next;
      apex_seen    <= mid.apex_flag;
    end
  end

endmodule

FILE: design/peak_background_area.sv
// top level: input register, region accumulator, hand-over register and output register
// depends on pba_pkg, pba_accum and pba_result
`timescale 1ns / 1ps

// Peak area against a sloped, clamped background. Samples of one region arrive first to
// last and one item is taken every clock cycle while in_stall is low; the background
// line, trapezoid sums and apex hold are updated by the accumulator as each item leaves
// the input register, so that loop sets the rate. A result is offered on out_valid once
// its last sample has passed the hand-over register, then the output register. While a
// result waits under out_stall, samples that are not last keep flowing; a last sample
// waits only when both the hand-over and output registers are full. bg_slope is written
// through cfg_we/cfg_data and should only change between regions.
module peak_background_area (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic signed [pba_pkg::SampleW-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [pba_pkg::SampleW-1:0] sample,
  input  logic                               first,
  input  logic                               is_apex,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pba_pkg::AreaW-1:0]   raw_area_x2,
  output logic signed [pba_pkg::AreaW-1:0]   bg_area_x2,
  output logic signed [pba_pkg::AreaW-1:0]   peak_area_x2,
  output logic signed [pba_pkg::SampleW-1:0] apex_raw,
  output logic signed [pba_pkg::HeightW-1:0] apex_height,
  output logic                               apex_seen
);
  import pba_pkg::*;

  logic signed [SampleW-1:0] bg_slope;

  logic    r_valid;
  item_t   r_item;
  logic    r_fire;
  logic    in_take;

  logic    mid_valid;
  result_t mid;
  result_t res_next;
  logic    mid_ready;
  logic    out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_slope <= '0;
    end else if (cfg_we) begin
      bg_slope <= cfg_data;
    end
  end

  // a sample that is not last never needs room downstream
  assign mid_ready = !mid_valid || out_ready;
  assign r_fire    = r_valid && (!r_item.last || mid_ready);
  assign in_stall  = r_valid && !r_fire;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_take) begin
      r_valid <= 1'b1;
    end else if (r_fire) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      r_item.sample  <= sample;
      r_item.first   <= first;
      r_item.is_apex <= is_apex;
      r_item.last    <= last;
    end
  end

  pba_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .step     (r_fire),
    .item     (r_item),
    .bg_slope (bg_slope),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (r_fire && r_item.last) begin
      mid_valid <= 1'b1;
    end else if (out_ready) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_fire && r_item.last) begin
      mid <= res_next;
    end
  end

  pba_result u_result (
    .clk          (clk),
    .rst          (rst),
    .mid_valid    (mid_valid),
    .mid          (mid),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .raw_area_x2  (raw_area_x2),
    .bg_area_x2   (bg_area_x2),
    .peak_area_x2 (peak_area_x2),
    .apex_raw     (apex_raw),
    .apex_height  (apex_height),
    .apex_seen    (apex_seen)
  );

`ifndef NO_ASSERTIONS
  // back-pressure only ever comes from an item held in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> r_valid)
    else $error("input stalled with an empty input register");

  // a waiting hand-over result is never dropped while the output is blocked
  a_mid_kept: assert property (@(posedge clk) disable iff (rst)
    mid_valid && !out_ready |=> mid_valid && $stable(mid))
    else $error("hand-over result lost under stall");

  // only a last sample creates a result
  a_mid_last: assert property (@(posedge clk) disable iff (rst)
    $rose(mid_valid) |-> $past(r_fire && r_item.last))
    else $error("result created without a last sample");

  // no apex in the region gives zero apex fields
  a_no_apex: assert property (@(posedge clk) disable iff (rst)
    out_valid && !apex_seen |-> apex_raw == '0 && apex_height == '0)
    else $error("apex fields set without an apex");
`endif

endmodule

FILE: sim/peak_background_area_tb.sv
// self-checking bench for peak_background_area: random regions under random stalls,
// predicted sample by sample in a small scoreboard class; depends on pba_pkg and the rtl
`timescale 1ns / 1ps

module peak_background_area_tb;
  import pba_pkg::*;

  typedef struct packed {
    logic signed [AreaW-1:0]   raw_tot;
    logic signed [AreaW-1:0]   bg_tot;
    logic signed [AreaW-1:0]   net_tot;
    logic signed [SampleW-1:0] apex_raw;
    logic signed [HeightW-1:0] apex_height;
    logic                      apex_seen;
  } area_result_t;

  class area_scoreboard;
    logic signed [SampleW-1:0] slope;
    logic signed [SampleW-1:0] line_val;
    logic signed [SampleW-1:0] prev_raw;
    logic signed [SampleW-1:0] prev_bg;
    logic signed [SampleW-1:0] apex_raw_h;
    logic signed [SampleW-1:0] apex_bg_h;
    logic signed [AreaW-1:0]   raw_sum;
    logic signed [AreaW-1:0]   bg_sum;
    bit                        apex_flag;
    area_result_t              pending[$];
    int                        errors;
    int                        checked;

    function new();
      slope = '0;
      line_val = '0;
      prev_raw = '0;
      prev_bg = '0;
      apex_raw_h = '0;
      apex_bg_h = '0;
      raw_sum = '0;
      bg_sum = '0;
      apex_flag = 0;
      errors = 0;
      checked = 0;
    endfunction

    function logic signed [AreaW-1:0] clamp48(longint v);
      longint hi;
      hi = (64'sd1 <<< (AreaW - 1)) - 1;
      if (v > hi) return hi[AreaW-1:0];
      if (v < -hi - 1) return ~hi[AreaW-1:0];
      return v[AreaW-1:0];
    endfunction

    function logic signed [SampleW-1:0] clamp32(longint v);
      longint hi;
      hi = (64'sd1 <<< (SampleW - 1)) - 1;
      if (v > hi) return hi[SampleW-1:0];
      if (v < -hi - 1) return ~hi[SampleW-1:0];
      return v[SampleW-1:0];
    endfunction

    // advance the region state by one accepted item
    function void note_input(logic signed [SampleW-1:0] s, logic f, logic a, logic l);
      logic signed [SampleW-1:0] bgp;
      area_result_t r;
      if (f) begin
        raw_sum = '0;
        bg_sum = '0;
        apex_flag = 0;
        apex_raw_h = '0;
        apex_bg_h = '0;
        line_val = s;
      end
      bgp = (s < line_val) ? s : line_val;
      if (!f) begin
        raw_sum = clamp48(longint'(raw_sum) + longint'(prev_raw) + longint'(s));
        bg_sum = clamp48(longint'(bg_sum) + longint'(prev_bg) + longint'(bgp));
      end
      if (a) begin
        apex_raw_h = s;
        apex_bg_h = bgp;
        apex_flag = 1;
      end
      prev_raw = s;
      prev_bg = bgp;
      line_val = clamp32(longint'(line_val) + longint'(slope));
      if (l) begin
        r.raw_tot = raw_sum;
        r.bg_tot = bg_sum;
        r.net_tot = clamp48(longint'(raw_sum) - longint'(bg_sum));
        r.apex_raw = apex_flag ? apex_raw_h : '0;
        r.apex_height = apex_flag ? HeightW'(longint'(apex_raw_h) - longint'(apex_bg_h)) : '0;
        r.apex_seen = apex_flag;
        pending.push_back(r);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare(string name, logic signed [63:0] got, logic signed [63:0] want);
      if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(area_result_t got);
      area_result_t want;
      checked++;
      if (pending.size() == 0) begin
        report("result with no region pending");
      end else begin
        want = pending.pop_front();
        compare("raw_area_x2", got.raw_tot, want.raw_tot);
        compare("bg_area_x2", got.bg_tot, want.bg_tot);
        compare("peak_area_x2", got.net_tot, want.net_tot);
        compare("apex_raw", got.apex_raw, want.apex_raw);
        compare("apex_height", got.apex_height, want.apex_height);
        compare("apex_seen", got.apex_seen, want.apex_seen);
      end
    endtask
  endclass

  localparam logic signed [SampleW-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [SampleW-1:0] S_MIN = 32'sh80000000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 8;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;
  typedef enum {APEX_NONE, APEX_ONE, APEX_SOME} apex_plan_t;
  typedef enum {STY_FULL, STY_SMALL, STY_EDGE, STY_NEAR_RAIL} sample_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic signed [SampleW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SampleW-1:0] sample = '0;
  logic first = 1'b0;
  logic is_apex = 1'b0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AreaW-1:0]   raw_area_x2;
  logic signed [AreaW-1:0]   bg_area_x2;
  logic signed [AreaW-1:0]   peak_area_x2;
  logic signed [SampleW-1:0] apex_raw;
  logic signed [HeightW-1:0] apex_height;
  logic                      apex_seen;

  area_scoreboard sb = new();

  int burst_left = 0;
  int items_sent = 0;
  int slope_writes = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_period = 2;
  int rx_cycle = 0;
  int idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;

  peak_background_area dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .first       (first),
    .is_apex     (is_apex),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .raw_area_x2 (raw_area_x2),
    .bg_area_x2  (bg_area_x2),
    .peak_area_x2(peak_area_x2),
    .apex_raw    (apex_raw),
    .apex_height (apex_height),
    .apex_seen   (apex_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sender side: bursts of items separated by random gaps
  task automatic put_item(input logic signed [SampleW-1:0] s, input logic f, input logic a,
                          input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    sample   <= s;
    first    <= f;
    is_apex  <= a;
    last     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(s, f, a, l);
    items_sent++;
    burst_left--;
  endtask

  // stop offering and let every pending region result come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // slope only changes with the block empty; non-last items leave no trace, so wait a bit
  task automatic write_slope(input logic signed [SampleW-1:0] v);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.slope = v;
    slope_writes++;
  endtask

  task automatic run_random(input int count);
    int done_items;
    int len;
    int apex_pos;
    int i;
    bit drop_last;
    apex_plan_t plan;
    sample_style_t style;
    logic signed [SampleW-1:0] base;
    logic signed [SampleW-1:0] s;
    logic a;
    done_items = 0;
    while (done_items < count) begin
      if ($urandom_range(0, 6) == 0) begin
        // loose item with arbitrary flags
        put_item($urandom, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
        done_items++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
        plan = apex_plan_t'($urandom_range(0, 2));
        style = sample_style_t'($urandom_range(0, 3));
        apex_pos = $urandom_range(0, len - 1);
        drop_last = ($urandom_range(0, 11) == 0);
        base = $urandom_range(0, 200000) - 100000;
        for (i = 0; i < len; i++) begin
          case (style)
            STY_FULL: begin
              s = $urandom;
            end
            STY_SMALL: begin
              s = base + $urandom_range(0, 8191) - 4096;
            end
            STY_EDGE: begin
              case ($urandom_range(0, 4))
                0: s = S_MAX;
                1: s = S_MIN;
                2: s = '0;
                3: s = -1;
                default: s = 1;
              endcase
            end
            default: begin
              s = $urandom_range(0, 1) ? S_MAX - $urandom_range(0, 5000)
                                       : S_MIN + $urandom_range(0, 5000);
            end
          endcase
          case (plan)
            APEX_ONE: a = (i == apex_pos);
            APEX_SOME: a = ($urandom_range(0, 3) == 0);
            default: a = 1'b0;
          endcase
          put_item(s, i == 0, a, (i == len - 1) && !drop_last);
        end
        done_items += len;
      end
    end
  endtask

  // receiver side: checks results and stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result({raw_area_x2, bg_area_x2, peak_area_x2, apex_raw, apex_height,
                         apex_seen});
      end
      if (hold_left == 0 && hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
          stall_period = $urandom_range(2, 5);
        end
        mode_left--;
        case (stall_mode)
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_PERIODIC: out_stall <= (rx_cycle % stall_period == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'b0;
        endcase
      end
      rx_cycle++;
    end
  end

  // cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
    $display("[peak_background_area] ERROR");
    $finish;
  end

  initial begin
    logic signed [SampleW-1:0] slopes[8];
    int p;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // continuation from reset state without a first mark
    put_item(32'sd1280, 1'b0, 1'b0, 1'b1);
    // single-sample regions with and without apex, then three-sample regions with the apex in the middle and at the end
    put_item(S_MAX, 1'b1, 1'b1, 1'b1);
    put_item(S_MIN, 1'b1, 1'b0, 1'b1);
    put_item(S_MAX, 1'b1, 1'b0, 1'b0);
    put_item(S_MAX, 1'b0, 1'b1, 1'b0);
    put_item(S_MAX, 1'b0, 1'b0, 1'b1);
    put_item(S_MIN, 1'b1, 1'b0, 1'b0);
    put_item(S_MIN, 1'b0, 1'b0, 1'b0);
    put_item(S_MIN, 1'b0, 1'b1, 1'b1);
    // several apex marks, the later one holds
    put_item(32'sd100, 1'b1, 1'b1, 1'b0);
    put_item(32'sd900, 1'b0, 1'b1, 1'b0);
    put_item(32'sd300, 1'b0, 1'b0, 1'b1);
    // line runs into the upper rail
    write_slope(S_MAX);
    put_item(32'sh7fffff00, 1'b1, 1'b0, 1'b0);
    put_item(32'sd0, 1'b0, 1'b1, 1'b0);
    put_item(S_MAX, 1'b0, 1'b0, 1'b1);
    // and into the lower one
    write_slope(S_MIN);
    put_item(32'sh80000100, 1'b1, 1'b0, 1'b0);
    put_item(S_MIN, 1'b0, 1'b1, 1'b0);
    put_item(-32'sd5, 1'b0, 1'b0, 1'b1);
    // line below and above the samples in one region
    write_slope(32'sd256);
    put_item(32'sd1000, 1'b1, 1'b0, 1'b0);
    put_item(32'sd2000, 1'b0, 1'b1, 1'b0);
    put_item(32'sd1500, 1'b0, 1'b0, 1'b0);
    put_item(32'sd100, 1'b0, 1'b0, 1'b1);

    slopes[0] = 32'sd1;
    slopes[1] = -32'sd1;
    slopes[2] = $urandom_range(0, 2047) - 1024;
    slopes[3] = 256 * $urandom_range(1, 16);
    slopes[4] = $urandom;
    slopes[5] = S_MIN;
    slopes[6] = S_MAX;
    slopes[7] = '0;
    for (p = 0; p < 8; p++) begin
      write_slope(slopes[p]);
      if (p == 2) begin
        // receiver sits on its output for a long while, sender keeps pushing
        run_random(50);
        hold_asked++;
        run_random(125);
      end else if (p == 5) begin
        run_random(90);
        drain();
        run_random(85);
      end else begin
        run_random(175);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("ran %0d samples through %0d background slope settings, %0d region results checked",
             items_sent, slope_writes, sb.checked);
    $display("regions covered full-range, small, rail and near-rail samples under random stalls");
    if (sb.errors == 0) begin
      $display("[peak_background_area] OK");
    end else begin
      $display("[peak_background_area] ERROR");
    end
    $finish;
  end

endmodule
